FILE: rtl/tbvrc_pkg.sv
// shared types, constants and codes of the two-bit value range counter
package tbvrc_pkg;

    localparam int unsigned IDX_W       = 10;    // slot_index and range_end
    localparam int unsigned CNT_W       = 11;    // count and tree node sums
    localparam int unsigned VAL_W       = 64;    // slot value
    localparam int unsigned IN_DATA_W   = 88;    // slot, end, value padded to bytes
    localparam int unsigned OUT_DATA_W  = 16;    // count padded to bytes
    localparam int unsigned DEF_SLOTS   = 1024;
    localparam int unsigned DEF_Q_DEPTH = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // what the back end has to do with one queued operation
    typedef enum logic [1:0] {
        KIND_WRITE,   // slot write inside the slot range
        KIND_SKIP,    // slot write beyond the slot range, no effect
        KIND_QUERY,   // valid range count
        KIND_ZERO     // invalid range, answers 0
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] last;
        logic             flag;
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_QRY_STEP,
        ST_QRY_ADD_L,
        ST_QRY_ADD_R,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/tbvrc_ram.sv
// generic simple dual port ram with registered read
module tbvrc_ram #(
    parameter int unsigned WIDTH = tbvrc_pkg::CNT_W,
    parameter int unsigned DEPTH = 2 * tbvrc_pkg::DEF_SLOTS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/tbvrc_front.sv
// front end: takes input beats, finds the two-bit flag and classifies the command
module tbvrc_front #(
    parameter int unsigned SLOTS = tbvrc_pkg::DEF_SLOTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_hold,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_command,
    input  logic [tbvrc_pkg::IDX_W-1:0] i_slot_index,
    input  logic [tbvrc_pkg::IDX_W-1:0] i_range_end,
    input  logic [tbvrc_pkg::VAL_W-1:0] i_value,
    output logic                        o_push,
    output tbvrc_pkg::t_op              o_op,
    input  logic                        i_q_ready
);
    import tbvrc_pkg::*;

    logic             r_a_valid;
    logic             r_a_cmd;
    logic [IDX_W-1:0] r_a_slot;
    logic [IDX_W-1:0] r_a_end;
    logic [VAL_W-1:0] r_a_value;

    logic             r_b_valid;
    logic             r_b_cmd;
    logic [IDX_W-1:0] r_b_slot;
    logic [IDX_W-1:0] r_b_end;
    logic [VAL_W-1:0] r_b_low_cut;   // value with its lowest set bit cleared
    logic             r_b_nz;
    logic             r_b_neg;

    logic a_adv;
    logic b_adv;
    logic accept;
    logic flag;

    assign b_adv   = !r_b_valid || i_q_ready;
    assign a_adv   = !r_a_valid || b_adv;
    assign o_ready = a_adv && !i_hold;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_adv) begin
                r_a_valid <= accept;
            end
            if (b_adv) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_cmd   <= i_command;
            r_a_slot  <= i_slot_index;
            r_a_end   <= i_range_end;
            r_a_value <= i_value;
        end
        if (b_adv && r_a_valid) begin
            r_b_cmd     <= r_a_cmd;
            r_b_slot    <= r_a_slot;
            r_b_end     <= r_a_end;
            r_b_low_cut <= r_a_value & (r_a_value - VAL_W'(1));
            r_b_nz      <= |r_a_value;
            r_b_neg     <= r_a_value[VAL_W-1];
        end
    end

    // exactly two ones and not negative: nonzero, one left after clearing the lowest, none after the next
    assign flag = !r_b_neg && r_b_nz && (|r_b_low_cut)
                  && !(|(r_b_low_cut & (r_b_low_cut - VAL_W'(1))));

    always_comb begin
        o_op      = '0;
        o_op.slot = r_b_slot;
        o_op.last = r_b_end;
        o_op.flag = flag;
        if (r_b_cmd == CMD_WRITE) begin
            o_op.kind = (32'(r_b_slot) < SLOTS) ? KIND_WRITE : KIND_SKIP;
        end else begin
            o_op.kind = ((r_b_slot > r_b_end) || (32'(r_b_end) >= SLOTS))
                        ? KIND_ZERO : KIND_QUERY;
        end
    end

    assign o_push = r_b_valid && i_q_ready;
endmodule

FILE: rtl/tbvrc_queue.sv
// small fifo of classified operations between front and back end
module tbvrc_queue #(
    parameter int unsigned DEPTH = tbvrc_pkg::DEF_Q_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tbvrc_pkg::t_op i_op,
    output logic           o_ready,
    output logic           o_valid,
    output tbvrc_pkg::t_op o_op,
    input  logic           i_pop
);
    import tbvrc_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_op          r_slots [DEPTH];
    logic [PTR_W:0] r_wr;
    logic [PTR_W:0] r_rd;

    assign o_valid = (r_wr != r_rd);
    assign o_ready = !((r_wr[PTR_W] != r_rd[PTR_W])
                       && (r_wr[PTR_W-1:0] == r_rd[PTR_W-1:0]));
    assign o_op    = r_slots[r_rd[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr[PTR_W-1:0]] <= i_op;
        end
    end
endmodule

FILE: rtl/tbvrc_back.sv
// back end: sequencer walking the segment tree held in ram
module tbvrc_back #(
    parameter int unsigned SLOTS = tbvrc_pkg::DEF_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    output logic                             o_busy,
    input  logic                             i_op_valid,
    input  tbvrc_pkg::t_op                   i_op,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tbvrc_pkg::CNT_W-1:0]      o_count
);
    import tbvrc_pkg::*;

    localparam int unsigned LOG_P  = $clog2(SLOTS);
    localparam int unsigned LEAVES = 1 << LOG_P;
    localparam int unsigned ADDR_W = LOG_P + 1;
    localparam int unsigned NODE_W = LOG_P + 2;   // range end may reach 2*LEAVES

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic [NODE_W-1:0]   r_node, n_node;
    logic                r_flag, n_flag;
    logic                r_leaf, n_leaf;
    logic [NODE_W-1:0]   r_lo, n_lo;
    logic [NODE_W-1:0]   r_hi, n_hi;
    logic [CNT_W-1:0]    r_sum, n_sum;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CNT_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CNT_W-1:0]    ram_rdata;

    logic                upd_done;
    logic                qry_end;

    tbvrc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (2 * LEAVES)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // leaf already holds the wanted flag, or the node being written is the root
    assign upd_done = (r_leaf && ((ram_rdata != '0) == r_flag))
                      || (r_node == NODE_W'(1));
    assign qry_end  = (r_lo >= r_hi);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_op_valid) begin
                    unique case (i_op.kind)
                        KIND_WRITE: n_state = ST_UPD_RD;
                        KIND_QUERY: n_state = ST_QRY_STEP;
                        KIND_ZERO:  n_state = ST_OUT;
                        KIND_SKIP:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_UPD_RD: n_state = ST_UPD_WR;
            ST_UPD_WR: begin
                if (upd_done) n_state = ST_IDLE;
            end
            ST_QRY_STEP: begin
                priority if (qry_end) n_state = ST_OUT;
                else if (r_lo[0])     n_state = ST_QRY_ADD_L;
                else if (r_hi[0])     n_state = ST_QRY_ADD_R;
                else                  n_state = ST_QRY_STEP;
            end
            ST_QRY_ADD_L: n_state = r_hi[0] ? ST_QRY_ADD_R : ST_QRY_STEP;
            ST_QRY_ADD_R: n_state = ST_QRY_STEP;
            ST_OUT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_clr     = r_clr;
        n_node    = r_node;
        n_flag    = r_flag;
        n_leaf    = r_leaf;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_sum     = r_sum;
        ram_we    = 1'b0;
        ram_waddr = r_node[ADDR_W-1:0];
        ram_wdata = '0;
        ram_raddr = r_node[ADDR_W-1:0];
        o_pop     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
            end
            ST_IDLE: begin
                o_pop  = i_op_valid;
                n_node = NODE_W'(LEAVES) + NODE_W'(i_op.slot);
                n_flag = i_op.flag;
                n_leaf = 1'b1;
                n_lo   = NODE_W'(LEAVES) + NODE_W'(i_op.slot);
                n_hi   = NODE_W'(LEAVES) + NODE_W'(i_op.last) + NODE_W'(1);
                n_sum  = '0;
            end
            ST_UPD_RD: begin
                ram_raddr = r_node[ADDR_W-1:0];
            end
            ST_UPD_WR: begin
                // write this node and fetch its parent in the same cycle
                ram_raddr = r_node[ADDR_W:1];
                if (!(r_leaf && ((ram_rdata != '0) == r_flag))) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_node[ADDR_W-1:0];
                    ram_wdata = r_flag ? ram_rdata + CNT_W'(1) : ram_rdata - CNT_W'(1);
                end
                n_node = r_node >> 1;
                n_leaf = 1'b0;
            end
            ST_QRY_STEP: begin
                if (!qry_end) begin
                    priority if (r_lo[0]) begin
                        ram_raddr = r_lo[ADDR_W-1:0];
                        n_lo      = r_lo + NODE_W'(1);
                    end else if (r_hi[0]) begin
                        ram_raddr = ADDR_W'(r_hi - NODE_W'(1));
                        n_hi      = r_hi - NODE_W'(1);
                    end else begin
                        n_lo = r_lo >> 1;
                        n_hi = r_hi >> 1;
                    end
                end
            end
            ST_QRY_ADD_L: begin
                n_sum = r_sum + ram_rdata;
                if (r_hi[0]) begin
                    ram_raddr = ADDR_W'(r_hi - NODE_W'(1));
                    n_hi      = r_hi - NODE_W'(1);
                end else begin
                    n_lo = r_lo >> 1;
                    n_hi = r_hi >> 1;
                end
            end
            ST_QRY_ADD_R: begin
                n_sum = r_sum + ram_rdata;
                n_lo  = r_lo >> 1;
                n_hi  = r_hi >> 1;
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_flag <= n_flag;
        r_leaf <= n_leaf;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_sum  <= n_sum;
    end

    assign o_busy      = (r_state == ST_CLEAR);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_count     = r_sum;
endmodule

FILE: rtl/two_bit_value_range_counter.sv
// top level of the two-bit value range counter
//
// counts, over SLOTS slots, how many hold a value with exactly two one bits
// (negative values never count). a beat with tuser 0 writes one slot, a beat
// with tuser 1 asks for the count over slots slot_index..range_end and gives
// one result beat; an empty or out-of-range span answers 0. writes give no
// result. after reset the block first zeroes its tree memory, one node per
// cycle, all 2*2^ceil(log2(SLOTS)) nodes (2048 at the default), with
// s_axis_tready low. the front end registers and classifies beats in two
// stages and feeds a small queue, so it keeps taking beats while the back
// end works or a result waits, until the queue fills. the back end walks a
// segment tree stored in one ram with one read and one write per cycle: a
// write reads the leaf, then writes it and each ancestor up to the root, or
// stops when the leaf already holds the flag; a query climbs the tree a level
// at a time, reading at most two nodes per level through the single read port.
module two_bit_value_range_counter #(
    parameter int unsigned SLOTS       = tbvrc_pkg::DEF_SLOTS,
    parameter int unsigned QUEUE_DEPTH = tbvrc_pkg::DEF_Q_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input beats
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: slot_index [9:0], range_end [19:10], value [83:20], zero pad
    input  logic [tbvrc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: command (0 write, 1 range count)
    input  logic                             s_axis_tuser,
    // result beats
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: count [10:0], zero pad
    output logic [tbvrc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tbvrc_pkg::*;

    logic             hold;
    logic             push;
    t_op              push_op;
    logic             q_ready;
    logic             q_valid;
    t_op              q_op;
    logic             pop;
    logic [CNT_W-1:0] count;

    // classify beats and compute the two-bit flag
    tbvrc_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold       (hold),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_command    (s_axis_tuser),
        .i_slot_index (s_axis_tdata[IDX_W-1:0]),
        .i_range_end  (s_axis_tdata[2*IDX_W-1:IDX_W]),
        .i_value      (s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W]),
        .o_push       (push),
        .o_op         (push_op),
        .i_q_ready    (q_ready)
    );

    // decouples beat intake from tree work
    tbvrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (pop)
    );

    // tree updates and range sums, result held until taken
    tbvrc_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_busy      (hold),
        .i_op_valid  (q_valid),
        .i_op        (q_op),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_count     (count)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - CNT_W){1'b0}}, count};
endmodule
